// ===== sv/lbp_pkg.sv =====
// Shared types, constants and the helper function of the link bandwidth pacer.
`timescale 1ns / 1ps

package lbp_pkg;

    // Fraction bits of cycles_per_byte.
    localparam int FRACTION_BITS = 16;

    localparam int TIME_W   = 64;
    localparam int LEN_W    = 16;
    localparam int CPB_W    = 48;
    localparam int DELAY_W  = 40;
    localparam int ROUTE_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIME_W-1:0] RNG_SEED_RESET = 64'd1;

    // Operation codes of an input item.
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_PAUSE  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CYCLES_PER_BYTE = 3'd0,
        CFG_PROP_DELAY      = 3'd1,
        CFG_DROP_LIMIT      = 3'd2,
        CFG_ROUTE_TAG       = 3'd3,
        CFG_RNG_SEED        = 3'd4
    } lbp_cfg_idx_t;

    typedef struct packed {
        logic              operation;
        logic [LEN_W-1:0]  packet_length;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] current_time;
    } lbp_in_t;

    typedef struct packed {
        logic               dropped;
        logic [TIME_W-1:0]  send_time;
        logic [TIME_W-1:0]  release_time;
        logic [TIME_W-1:0]  reference_time;
        logic [ROUTE_W-1:0] route;
    } lbp_out_t;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        logic              is_pause;
        logic [TIME_W-1:0] ser_cycles;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] current_time;
    } lbp_item_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [DELAY_W-1:0] prop_delay;
        logic [TIME_W-1:0]  drop_limit;
        logic [ROUTE_W-1:0] route_tag;
        logic               seed_load;
        logic [TIME_W-1:0]  rng_seed;
    } lbp_cfg_t;

    // One xorshift64 step.
    function automatic logic [TIME_W-1:0] xorshift64(input logic [TIME_W-1:0] s_in);
        logic [TIME_W-1:0] s;
        s = s_in;
        s = s ^ (s << 13);
        s = s ^ (s >> 7);
        s = s ^ (s << 17);
        return s;
    endfunction

endpackage

// ===== sv/lbp_front.sv =====
// Front end: accept items, classify them and work out serialization cycles.
`timescale 1ns / 1ps

module lbp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lbp_pkg::lbp_in_t              s_data,
    input  logic [lbp_pkg::CPB_W-1:0]     cycles_per_byte,
    output logic                          q_valid,
    input  logic                          q_ready,
    output lbp_pkg::lbp_item_t            q_item
);

    logic                                           valid_reg;
    logic                                           valid_next;
    lbp_pkg::lbp_item_t                             item_reg;
    logic [lbp_pkg::LEN_W+lbp_pkg::CPB_W-1:0]       product;
    logic [lbp_pkg::TIME_W-1:0]                     ser_cycles;
    logic                                           take;

    assign s_ready = !valid_reg || q_ready;
    assign take    = s_valid && s_ready;

    // 16 x 48 product always fits in 64 bits.
    assign product    = {{lbp_pkg::CPB_W{1'b0}}, s_data.packet_length}
                        * {{lbp_pkg::LEN_W{1'b0}}, cycles_per_byte};
    assign ser_cycles = lbp_pkg::TIME_W'(product >> lbp_pkg::FRACTION_BITS);

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.is_pause     <= (s_data.operation == lbp_pkg::OP_PAUSE);
            item_reg.ser_cycles   <= ser_cycles;
            item_reg.arrival_time <= s_data.arrival_time;
            item_reg.current_time <= s_data.current_time;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// ===== sv/lbp_queue.sv =====
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module lbp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  lbp_pkg::lbp_item_t  wr_item,
    output logic                rd_valid,
    input  logic                rd_ready,
    output lbp_pkg::lbp_item_t  rd_item
);

    lbp_pkg::lbp_item_t                 mem [lbp_pkg::QUEUE_DEPTH];
    logic [lbp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [lbp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [lbp_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [lbp_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic                               push;
    logic                               pop;

    assign wr_ready = (count_reg != lbp_pkg::QUEUE_CNT_W'(lbp_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== sv/lbp_back.sv =====
// Back end: pace packets, apply random loss and present results.
`timescale 1ns / 1ps

module lbp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  lbp_pkg::lbp_item_t    q_item,
    input  lbp_pkg::lbp_cfg_t     cfg,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lbp_pkg::lbp_out_t     m_data
);

    // Pacing state.
    logic [lbp_pkg::TIME_W-1:0] last_send_reg;
    logic [lbp_pkg::TIME_W-1:0] last_send_next;
    logic                       reanchor_reg;
    logic                       reanchor_next;
    logic [lbp_pkg::TIME_W-1:0] rand_reg;
    logic [lbp_pkg::TIME_W-1:0] rand_next;

    // Pacing stage.
    logic                       b1_valid_reg;
    logic                       b1_valid_next;
    logic [lbp_pkg::TIME_W-1:0] b1_send_reg;
    logic [lbp_pkg::TIME_W-1:0] b1_arrival_reg;
    logic                       b1_drop_reg;

    // Output stage.
    logic                       out_valid_reg;
    logic                       out_valid_next;
    lbp_pkg::lbp_out_t          out_reg;

    logic                       b1_adv;
    logic                       b1_free;
    logic                       pop;
    logic                       load_b1;
    logic                       loss_on;
    logic [lbp_pkg::TIME_W-1:0] draw;
    logic                       drop;
    logic [lbp_pkg::TIME_W-1:0] base;
    logic [lbp_pkg::TIME_W-1:0] send;
    logic [lbp_pkg::TIME_W-1:0] delay_ext;

    assign b1_adv  = b1_valid_reg && (!out_valid_reg || m_ready);
    assign b1_free = !b1_valid_reg || b1_adv;
    // Pause events need no slot in the pacing stage.
    assign q_ready = q_item.is_pause || b1_free;
    assign pop     = q_valid && q_ready;
    assign load_b1 = pop && !q_item.is_pause;

    assign loss_on = (cfg.drop_limit != '0);
    assign draw    = lbp_pkg::xorshift64(rand_reg);
    assign drop    = loss_on && (draw < cfg.drop_limit);

    always_comb begin
        if (reanchor_reg) begin
            base = q_item.current_time;
        end else if (q_item.arrival_time > last_send_reg) begin
            base = q_item.arrival_time;
        end else begin
            base = last_send_reg;
        end
    end

    assign send      = base + q_item.ser_cycles;
    assign delay_ext = lbp_pkg::TIME_W'(cfg.prop_delay);

    always_comb begin
        last_send_next = load_b1 ? send : last_send_reg;

        reanchor_next = reanchor_reg;
        if (pop && q_item.is_pause) begin
            reanchor_next = 1'b1;
        end else if (load_b1) begin
            reanchor_next = 1'b0;
        end

        rand_next = rand_reg;
        if (cfg.seed_load) begin
            rand_next = cfg.rng_seed;
        end else if (load_b1 && loss_on) begin
            rand_next = draw;
        end

        b1_valid_next = b1_valid_reg;
        if (load_b1) begin
            b1_valid_next = 1'b1;
        end else if (b1_adv) begin
            b1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (b1_adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_send_reg <= '0;
            reanchor_reg  <= 1'b0;
            rand_reg      <= lbp_pkg::RNG_SEED_RESET;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            last_send_reg <= last_send_next;
            reanchor_reg  <= reanchor_next;
            rand_reg      <= rand_next;
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_b1) begin
            b1_send_reg    <= send;
            b1_arrival_reg <= q_item.arrival_time;
            b1_drop_reg    <= drop;
        end
        if (b1_adv) begin
            out_reg.dropped   <= b1_drop_reg;
            out_reg.send_time <= b1_send_reg;
            if (b1_drop_reg) begin
                out_reg.release_time   <= '0;
                out_reg.reference_time <= '0;
                out_reg.route          <= '0;
            end else begin
                out_reg.release_time   <= b1_send_reg + delay_ext;
                out_reg.reference_time <= b1_arrival_reg + delay_ext;
                out_reg.route          <= cfg.route_tag;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A stalled pacing stage keeps its packet.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b1_valid_reg && !b1_adv) |=> (b1_valid_reg && $stable(b1_send_reg)))
        else $error("pacing stage lost or altered a stalled packet");

    // xorshift never reaches zero from a nonzero state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rand_reg != '0 && !cfg.seed_load) |=> (rand_reg != '0))
        else $error("random state collapsed to zero");

    // A paced packet consumes a pending re-anchor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_b1 |=> !reanchor_reg)
        else $error("re-anchor still pending after a packet");

    // Dropped results carry no release, reference or route.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.dropped) |->
            (out_reg.release_time == '0 && out_reg.reference_time == '0
             && out_reg.route == '0))
        else $error("dropped result carries release data");

endmodule

// ===== sv/link_bandwidth_pacer_with_loss.sv =====
// Top level of the serializing link bandwidth pacer with random loss.
// A packet goes through the front register, the queue, the pacing and output stages.
// Throughput: one item per cycle unless m_ready stalls, set by the max-and-add pacing loop.
// Pause events take one queue slot and give no result transfer.
// Reset (aresetn low, synchronous) empties every stage and the queue, clears the
// pacing state and loads the registers with their reset values (seed 1).
`timescale 1ns / 1ps

module link_bandwidth_pacer_with_loss (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input item channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lbp_pkg::lbp_in_t                    s_data,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output lbp_pkg::lbp_out_t                   m_data,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers
    logic [lbp_pkg::CPB_W-1:0]      cpb_reg;
    logic [lbp_pkg::DELAY_W-1:0]    delay_reg;
    logic [lbp_pkg::TIME_W-1:0]     threshold_reg;
    logic [lbp_pkg::ROUTE_W-1:0]    route_reg;
    logic [lbp_pkg::TIME_W-1:0]     seed_reg;

    logic                           cfg_write;
    logic                           seed_load;
    lbp_pkg::lbp_cfg_t              back_cfg;

    // Front-to-queue and queue-to-back links
    logic                           fq_valid;
    logic                           fq_ready;
    lbp_pkg::lbp_item_t             fq_item;
    logic                           qb_valid;
    logic                           qb_ready;
    lbp_pkg::lbp_item_t             qb_item;

    // Always take register writes; the user must land them while idle (not enforced).
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    // Reload the generator whenever the seed is written.
    assign seed_load = cfg_write && (cfg_index == lbp_pkg::CFG_RNG_SEED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpb_reg       <= '0;
            delay_reg     <= '0;
            threshold_reg <= '0;
            route_reg     <= '0;
            seed_reg      <= lbp_pkg::RNG_SEED_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                lbp_pkg::CFG_CYCLES_PER_BYTE: begin
                    cpb_reg <= cfg_data[lbp_pkg::CPB_W-1:0];
                end
                lbp_pkg::CFG_PROP_DELAY: begin
                    delay_reg <= cfg_data[lbp_pkg::DELAY_W-1:0];
                end
                lbp_pkg::CFG_DROP_LIMIT: begin
                    threshold_reg <= cfg_data;
                end
                lbp_pkg::CFG_ROUTE_TAG: begin
                    route_reg <= cfg_data[lbp_pkg::ROUTE_W-1:0];
                end
                lbp_pkg::CFG_RNG_SEED: begin
                    seed_reg <= cfg_data;
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    always_comb begin
        back_cfg.prop_delay     = delay_reg;
        back_cfg.drop_limit     = threshold_reg;
        back_cfg.route_tag      = route_reg;
        back_cfg.seed_load      = seed_load;
        // Feed the incoming seed straight through so the load lands at the write edge.
        back_cfg.rng_seed       = seed_load ? cfg_data : seed_reg;
    end

    // Front end: accept the transfer, classify it, form the serialization time.
    lbp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .cycles_per_byte (cpb_reg),
        .q_valid         (fq_valid),
        .q_ready         (fq_ready),
        .q_item          (fq_item)
    );

    // Queue: let either side stall on its own.
    lbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    // Back end: advance the link clock, draw for loss, add the delay.
    lbp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_item  (qb_item),
        .cfg     (back_cfg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
